>>> rtl/mfpa_pkg.sv
// ----------------------------------------------------------------------------
// mfpa_pkg
// shared types and constants of the meter frame parser and interval averager
// ----------------------------------------------------------------------------
package mfpa_pkg;

    // frame layout
    localparam int unsigned FRAME_LENGTH = 28;
    localparam logic [7:0]  SYM_START    = 8'hFC;
    localparam logic [7:0]  SYM_ESC      = 8'hFD;
    localparam logic [7:0]  SYM_END      = 8'hFE;

    // byte positions of the little-endian fields
    localparam logic [5:0]  POS_LEN      = 6'd1;
    localparam logic [5:0]  POS_VOLT_LO  = 6'd4;
    localparam logic [5:0]  POS_VOLT_HI  = 6'd5;
    localparam logic [5:0]  POS_CURR_LO  = 6'd6;
    localparam logic [5:0]  POS_CURR_HI  = 6'd7;
    localparam logic [5:0]  POS_CONS_LO  = 6'd8;
    localparam logic [5:0]  POS_CONS_HI  = 6'd9;
    localparam logic [5:0]  POS_PWR_LO   = 6'd21;
    localparam logic [5:0]  POS_PWR_HI   = 6'd22;
    localparam logic [5:0]  POS_CSUM     = 6'(FRAME_LENGTH);
    localparam logic [5:0]  POS_MAX      = 6'd63;

    // configuration register indexes
    localparam logic [1:0]  REG_VOLT_LIMIT = 2'd0;
    localparam logic [1:0]  REG_CURR_LIMIT = 2'd1;
    localparam logic [1:0]  REG_PWR_LIMIT  = 2'd2;
    localparam logic [1:0]  REG_INTERVAL   = 2'd3;

    // reset values of the registers
    localparam logic [14:0] RST_VOLT_LIMIT = 15'd430;
    localparam logic [14:0] RST_CURR_LIMIT = 15'd2000;
    localparam logic [14:0] RST_PWR_LIMIT  = 15'd8600;
    localparam logic [31:0] RST_INTERVAL   = 32'd1000;

    localparam int unsigned DEF_COUNT_BITS = 16;

    // rounded dividend is 33 bits wide, one quotient bit per step
    localparam int unsigned DIV_BITS  = 33;
    localparam int unsigned NUM_MEANS = 3;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_FRAME = 2'd1,
        PH_ESC   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_LOAD  = 3'd1,
        S_ROUND = 3'd2,
        S_DIV   = 3'd3,
        S_STORE = 3'd4,
        S_OUT   = 3'd5
    } t_state;

    // strict signed magnitude check against an exclusive bound
    function automatic logic in_bound(logic [15:0] v, logic [14:0] lim);
        logic signed [16:0] s;
        logic signed [16:0] l;
        s = signed'({v[15], v});
        l = signed'({2'b00, lim});
        return (s > -l) && (s < l);
    endfunction

endpackage

>>> rtl/meter_frame_parse_average_top.sv
// ----------------------------------------------------------------------------
// meter_frame_parse_average_top
// serial meter frame parser with interval averaging of voltage, current, power
// ----------------------------------------------------------------------------
// input stream: s_axis_tuser selects a received byte (0) or a millisecond
// tick (1); s_axis_tdata carries the byte. every request yields exactly one
// result on the output stream. m_axis_tuser flags a report; its tdata holds
// the three rounded means, the last consumption and the checksum error count.
// a byte, or a tick that ends no reporting interval with samples, is answered
// from the output register in the cycle after it is taken. a tick that ends
// an interval with samples runs three divisions on one shared bit-serial
// divider (load, round, 33 steps, store), then hands the report on; the
// input is not ready meanwhile. configuration: plain write port; the user
// writes it only while no request is in flight; the block does not enforce it.
// reset (synchronous, active low) restores register defaults, drops any frame
// in progress, clears sums and counts and empties the output register.
// a stalled receiver holds the result in the output register; the input side
// stays ready only while that register is empty or being emptied.
// ----------------------------------------------------------------------------
module meter_frame_parse_average_top
    import mfpa_pkg::*;
#(
    parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value
    input  logic        s_axis_tuser,   // mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // avg_voltage, avg_current, avg_power,
                                        // energy_reading, checksum_errors
    output logic        m_axis_tuser    // report_valid
);

    // configuration registers
    logic [14:0] r_lim_v, r_lim_c, r_lim_p;
    logic [31:0] r_interval;

    // frame parser state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_sum8, n_sum8;
    logic [1:0]  r_end_cnt, n_end_cnt;
    logic [5:0]  r_pos, n_pos;
    logic [7:0]  r_decl, n_decl;
    logic [15:0] r_volt, n_volt;
    logic [15:0] r_curr, n_curr;
    logic [15:0] r_cons, n_cons;
    logic [15:0] r_pwr, n_pwr;
    logic        r_sum_ok, n_sum_ok;

    // interval accumulation
    logic [31:0]           r_tot_v, n_tot_v;
    logic [31:0]           r_tot_c, n_tot_c;
    logic [31:0]           r_tot_p, n_tot_p;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [15:0]           r_last_cons, n_last_cons;
    logic [15:0]           r_err, n_err;
    logic [31:0]           r_elapsed, n_elapsed;

    // sequencer and shared divider
    t_state                r_state, n_state;
    logic [1:0]            r_idx, n_idx;
    logic [5:0]            r_step, n_step;
    logic [DIV_BITS-1:0]   r_dvd, n_dvd;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [15:0]           r_quot, n_quot;
    logic                  r_neg, n_neg;
    logic [15:0]           r_avg [NUM_MEANS];
    logic [15:0]           n_avg [NUM_MEANS];

    // output register
    logic        r_out_valid, n_out_valid;
    logic        r_out_user, n_out_user;
    logic [79:0] r_out_data, n_out_data;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  in_fire;
    logic                  out_free;
    logic                  do_take;
    logic                  do_close;
    logic [7:0]            b;
    logic [31:0]           tot_sel;
    logic [DIV_BITS-1:0]   tot_ext;
    logic [COUNT_BITS:0]   trial;
    logic                  trial_ge;
    logic [31:0]           elapsed_inc;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;

    // divider operand select and one restoring step
    always_comb begin
        case (r_idx)
            2'd0:    tot_sel = r_tot_v;
            2'd1:    tot_sel = r_tot_c;
            default: tot_sel = r_tot_p;
        endcase
    end
    assign tot_ext     = {tot_sel[31], tot_sel};
    assign trial       = {r_rem, r_dvd[DIV_BITS-1]};
    assign trial_ge    = trial >= {1'b0, r_count};
    assign elapsed_inc = r_elapsed + 32'd1;

    // frame parser: which action the current byte takes
    always_comb begin
        do_take  = 1'b0;
        do_close = 1'b0;
        case (r_phase)
            PH_FRAME: begin
                if (b == SYM_ESC) begin
                    do_take = 1'b0;
                end else if (b == SYM_END) begin
                    do_close = (r_end_cnt != 2'd0);
                end else if (r_pos > 6'd1 &&
                             ({3'b000, r_pos} > ({1'b0, r_decl} + 9'd1) ||
                              r_decl != 8'(FRAME_LENGTH))) begin
                    do_take = 1'b0;
                end else begin
                    do_take = 1'b1;
                end
            end
            PH_ESC:  do_take = 1'b1;
            default: do_take = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_sum8      = r_sum8;
        n_end_cnt   = r_end_cnt;
        n_pos       = r_pos;
        n_decl      = r_decl;
        n_volt      = r_volt;
        n_curr      = r_curr;
        n_cons      = r_cons;
        n_pwr       = r_pwr;
        n_sum_ok    = r_sum_ok;
        n_tot_v     = r_tot_v;
        n_tot_c     = r_tot_c;
        n_tot_p     = r_tot_p;
        n_count     = r_count;
        n_last_cons = r_last_cons;
        n_err       = r_err;
        n_elapsed   = r_elapsed;
        n_idx       = r_idx;
        n_step      = r_step;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_neg       = r_neg;
        n_avg       = r_avg;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_user  = r_out_user;
        n_out_data  = r_out_data;

        case (r_state)
            S_IDLE: begin
                if (in_fire && !s_axis_tuser) begin
                    // received byte: parse, answer with the error count
                    case (r_phase)
                        PH_FRAME: begin
                            if (b == SYM_ESC) begin
                                n_phase = PH_ESC;
                            end else if (b == SYM_END) begin
                                n_end_cnt = r_end_cnt + 2'd1;
                            end else if (!do_take) begin
                                n_phase = PH_WAIT;   // bad length or overrun
                            end
                        end
                        PH_ESC: begin
                            n_phase = PH_FRAME;
                        end
                        default: begin
                            if (b == SYM_START) begin
                                n_phase   = PH_FRAME;
                                n_sum8    = 8'd0;
                                n_end_cnt = 2'd0;
                                n_pos     = 6'd0;
                                n_decl    = 8'd0;
                                n_volt    = 16'd0;
                                n_curr    = 16'd0;
                                n_cons    = 16'd0;
                                n_pwr     = 16'd0;
                                n_sum_ok  = 1'b0;
                            end
                        end
                    endcase

                    if (do_take) begin
                        case (r_pos)
                            POS_LEN:     n_decl = b;
                            POS_VOLT_LO: n_volt = {8'd0, b};
                            POS_VOLT_HI: n_volt = {b, r_volt[7:0]};
                            POS_CURR_LO: n_curr = {8'd0, b};
                            POS_CURR_HI: n_curr = {b, r_curr[7:0]};
                            POS_CONS_LO: n_cons = {8'd0, b};
                            POS_CONS_HI: n_cons = {b, r_cons[7:0]};
                            POS_PWR_LO:  n_pwr  = {8'd0, b};
                            POS_PWR_HI:  n_pwr  = {b, r_pwr[7:0]};
                            default:     n_decl = r_decl;
                        endcase
                        if (r_pos == POS_CSUM) begin
                            n_sum_ok = (r_sum8 == b);
                        end else begin
                            n_sum8 = r_sum8 + b;
                        end
                        n_end_cnt = 2'd0;
                        n_pos     = (r_pos == POS_MAX) ? POS_MAX : r_pos + 6'd1;
                    end

                    if (do_close) begin
                        n_phase = PH_WAIT;
                        if (r_sum_ok && in_bound(r_volt, r_lim_v) &&
                            in_bound(r_curr, r_lim_c) && in_bound(r_pwr, r_lim_p)) begin
                            if (r_count != COUNT_MAX) begin
                                n_tot_v     = r_tot_v + {{16{r_volt[15]}}, r_volt};
                                n_tot_c     = r_tot_c + {{16{r_curr[15]}}, r_curr};
                                n_tot_p     = r_tot_p + {{16{r_pwr[15]}}, r_pwr};
                                n_last_cons = r_cons;
                                n_count     = r_count + COUNT_BITS'(1);
                            end
                        end else if (!r_sum_ok && r_err != 16'hFFFF) begin
                            n_err = r_err + 16'd1;
                        end
                    end

                    n_out_valid = 1'b1;
                    n_out_user  = 1'b0;
                    n_out_data  = {n_err, 64'd0};
                end else if (in_fire) begin
                    // millisecond tick
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= r_interval) begin
                        n_elapsed = 32'd0;
                        if (r_count != '0) begin
                            n_idx   = 2'd0;
                            n_state = S_LOAD;
                        end else begin
                            n_tot_v     = 32'd0;
                            n_tot_c     = 32'd0;
                            n_tot_p     = 32'd0;
                            n_last_cons = 16'd0;
                            n_out_valid = 1'b1;
                            n_out_user  = 1'b0;
                            n_out_data  = {r_err, 64'd0};
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_user  = 1'b0;
                        n_out_data  = {r_err, 64'd0};
                    end
                end
            end
            S_LOAD: begin
                // magnitude of the selected total
                n_neg   = tot_sel[31];
                n_dvd   = tot_sel[31] ? (DIV_BITS'(0) - tot_ext) : tot_ext;
                n_rem   = '0;
                n_step  = 6'd0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                // bias by half the divisor for round half away from zero
                n_dvd   = r_dvd + DIV_BITS'(r_count >> 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = trial_ge ? COUNT_BITS'(trial - {1'b0, r_count})
                                  : trial[COUNT_BITS-1:0];
                n_quot = {r_quot[14:0], trial_ge};
                n_dvd  = {r_dvd[DIV_BITS-2:0], 1'b0};
                n_step = r_step + 6'd1;
                if (r_step == 6'(DIV_BITS - 1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_avg[r_idx] = r_neg ? (16'd0 - r_quot) : r_quot;
                if (r_idx == 2'(NUM_MEANS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = 1'b1;
                    n_out_data  = {r_err, r_last_cons, r_avg[2], r_avg[1], r_avg[0]};
                    n_tot_v     = 32'd0;
                    n_tot_c     = 32'd0;
                    n_tot_p     = 32'd0;
                    n_count     = '0;
                    n_last_cons = 16'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_v     <= RST_VOLT_LIMIT;
            r_lim_c     <= RST_CURR_LIMIT;
            r_lim_p     <= RST_PWR_LIMIT;
            r_interval  <= RST_INTERVAL;
            r_state     <= S_IDLE;
            r_phase     <= PH_WAIT;
            r_sum8      <= 8'd0;
            r_end_cnt   <= 2'd0;
            r_pos       <= 6'd0;
            r_decl      <= 8'd0;
            r_volt      <= 16'd0;
            r_curr      <= 16'd0;
            r_cons      <= 16'd0;
            r_pwr       <= 16'd0;
            r_sum_ok    <= 1'b0;
            r_tot_v     <= 32'd0;
            r_tot_c     <= 32'd0;
            r_tot_p     <= 32'd0;
            r_count     <= '0;
            r_last_cons <= 16'd0;
            r_err       <= 16'd0;
            r_elapsed   <= 32'd0;
            r_idx       <= 2'd0;
            r_step      <= 6'd0;
            r_out_valid <= 1'b0;
            r_out_user  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_VOLT_LIMIT: r_lim_v    <= i_cfg_wdata[14:0];
                    REG_CURR_LIMIT: r_lim_c    <= i_cfg_wdata[14:0];
                    REG_PWR_LIMIT:  r_lim_p    <= i_cfg_wdata[14:0];
                    REG_INTERVAL:   r_interval <= i_cfg_wdata;
                    default:        r_interval <= r_interval;
                endcase
            end
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_sum8      <= n_sum8;
            r_end_cnt   <= n_end_cnt;
            r_pos       <= n_pos;
            r_decl      <= n_decl;
            r_volt      <= n_volt;
            r_curr      <= n_curr;
            r_cons      <= n_cons;
            r_pwr       <= n_pwr;
            r_sum_ok    <= n_sum_ok;
            r_tot_v     <= n_tot_v;
            r_tot_c     <= n_tot_c;
            r_tot_p     <= n_tot_p;
            r_count     <= n_count;
            r_last_cons <= n_last_cons;
            r_err       <= n_err;
            r_elapsed   <= n_elapsed;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_out_user  <= n_out_user;
        end
    end

    // divider datapath and result payload
    always_ff @(posedge i_clk) begin
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_quot     <= n_quot;
        r_neg      <= n_neg;
        r_avg      <= n_avg;
        r_out_data <= n_out_data;
    end

endmodule

>>> rtl/mfpa_chk.sv
// ----------------------------------------------------------------------------
// mfpa_chk
// port-level checks of the meter frame parser, bound to the top level
// ----------------------------------------------------------------------------
module mfpa_chk
    import mfpa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a result without the report flag carries no averages or reading
    a_no_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:0] == 64'd0)
        else $error("non-report result carries data");

    // input is only taken when the output register has room
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("request taken with output register full");

    // a serial byte is answered the next cycle
    a_byte_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> m_axis_tvalid)
        else $error("byte request not answered");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind meter_frame_parse_average_top mfpa_chk u_mfpa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the meter frame parser and interval averager
// ----------------------------------------------------------------------------
// byte and tick requests go in on the slave stream. A scoreboard class keeps
// its own copy of the deframer, the checksum, the interval sums and the error
// count. It works out the one result of every accepted request and compares
// it field by field with what comes out of the master stream. A short directed
// part covers bytes outside a frame, an aborted length, an early close,
// limit edges and rounding. Random phases follow, each with fresh register
// settings: well-formed frames with random content, corrupted frames, ticks,
// line noise, random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb;
    import mfpa_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_ITEMS    = 60;

    // request kinds carried on tuser
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // shapes of generated frames
    typedef enum {
        FR_GOOD,
        FR_BAD_SUM,
        FR_EARLY_CLOSE,
        FR_BAD_LEN,
        FR_OVERRUN,
        FR_ESC_TAIL
    } t_frame_kind;

    // one result as the block should present it
    typedef struct packed {
        logic        report;
        logic [15:0] avg_volt;
        logic [15:0] avg_curr;
        logic [15:0] avg_pwr;
        logic [15:0] energy;
        logic [15:0] bad_frames;
    } t_meter_result;

    // one request on the slave stream
    typedef struct packed {
        logic       tick;
        logic [7:0] value;
    } t_request;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = REG_VOLT_LIMIT;
    logic [31:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // byte_value
    logic        s_axis_tuser  = MODE_BYTE;    // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // avg_voltage, avg_current, avg_power,
                                        // energy_reading, checksum_errors
    logic        m_axis_tuser;          // report_valid

    meter_frame_parse_average_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // scoreboard: own copy of parser and averager, queue of expected results
    // ------------------------------------------------------------------------
    class meter_scoreboard;
        logic [14:0]   volt_limit;
        logic [14:0]   curr_limit;
        logic [14:0]   pwr_limit;
        logic [31:0]   interval_ms;
        t_phase        phase;
        logic [7:0]    sum8;
        logic [1:0]    end_run;
        logic [5:0]    pos;
        logic [7:0]    len_byte;
        logic [15:0]   volt_f;
        logic [15:0]   curr_f;
        logic [15:0]   cons_f;
        logic [15:0]   pwr_f;
        bit            sum_ok;
        logic [31:0]   volt_total;
        logic [31:0]   curr_total;
        logic [31:0]   pwr_total;
        logic [15:0]   n_samples;
        logic [15:0]   last_cons;
        logic [15:0]   bad_frames;
        logic [31:0]   ticks;
        t_meter_result pending[$];
        int unsigned   fail_count;

        function new();
            volt_limit  = RST_VOLT_LIMIT;
            curr_limit  = RST_CURR_LIMIT;
            pwr_limit   = RST_PWR_LIMIT;
            interval_ms = RST_INTERVAL;
            phase       = PH_WAIT;
            sum8        = '0;
            end_run     = '0;
            pos         = '0;
            len_byte    = '0;
            volt_f      = '0;
            curr_f      = '0;
            cons_f      = '0;
            pwr_f       = '0;
            sum_ok      = 1'b0;
            volt_total  = '0;
            curr_total  = '0;
            pwr_total   = '0;
            n_samples   = '0;
            last_cons   = '0;
            bad_frames  = '0;
            ticks       = '0;
            fail_count  = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_VOLT_LIMIT: volt_limit  = val[14:0];
                REG_CURR_LIMIT: curr_limit  = val[14:0];
                REG_PWR_LIMIT:  pwr_limit   = val[14:0];
                default:        interval_ms = val;
            endcase
        endfunction

        // strict magnitude bound on a signed field
        function bit within_limit(logic [15:0] v, logic [14:0] lim);
            int s;
            int l;
            s = $signed(v);
            l = int'(lim);
            return (s > -l) && (s < l);
        endfunction

        // mean of a wrapped 32-bit total, half away from zero
        function logic [15:0] rounded_mean(logic [31:0] total, logic [15:0] n);
            longint          s;
            longint unsigned mag;
            longint unsigned q;
            longint unsigned nn;
            s   = longint'($signed(total));
            nn  = n;
            mag = (s < 0) ? -s : s;
            q   = (mag + nn / 2) / nn;
            return (s < 0) ? 16'(-q) : 16'(q);
        endfunction

        function void store_byte(logic [7:0] b);
            case (pos)
                POS_LEN:     len_byte      = b;
                POS_VOLT_LO: volt_f        = {8'h00, b};
                POS_VOLT_HI: volt_f[15:8]  = b;
                POS_CURR_LO: curr_f        = {8'h00, b};
                POS_CURR_HI: curr_f[15:8]  = b;
                POS_CONS_LO: cons_f        = {8'h00, b};
                POS_CONS_HI: cons_f[15:8]  = b;
                POS_PWR_LO:  pwr_f         = {8'h00, b};
                POS_PWR_HI:  pwr_f[15:8]   = b;
                default: ;
            endcase
            if (pos == POS_CSUM) begin
                sum_ok = (sum8 == b);
            end else begin
                sum8 = sum8 + b;
            end
            end_run = '0;
            if (pos != POS_MAX) pos = pos + 6'd1;
        endfunction

        function void close_frame();
            if (sum_ok && within_limit(volt_f, volt_limit) &&
                within_limit(curr_f, curr_limit) && within_limit(pwr_f, pwr_limit)) begin
                // a full sample counter drops further frames
                if (n_samples != '1) begin
                    volt_total = volt_total + 32'($signed(volt_f));
                    curr_total = curr_total + 32'($signed(curr_f));
                    pwr_total  = pwr_total + 32'($signed(pwr_f));
                    last_cons  = cons_f;
                    n_samples  = n_samples + 16'd1;
                end
            end else if (!sum_ok && bad_frames != '1) begin
                bad_frames = bad_frames + 16'd1;
            end
            phase = PH_WAIT;
        endfunction

        function void note_request(logic mode, logic [7:0] b);
            t_meter_result r;
            r = '0;
            if (mode == MODE_BYTE) begin
                case (phase)
                    PH_FRAME: begin
                        if (b == SYM_ESC) begin
                            phase = PH_ESC;
                        end else if (b == SYM_END) begin
                            end_run = end_run + 2'd1;
                            if (end_run >= 2) close_frame();
                        end else if (pos > 1 && (int'(pos) > int'(len_byte) + 1 ||
                                                 len_byte != FRAME_LENGTH)) begin
                            // wrong length or overrun drops the frame quietly
                            phase = PH_WAIT;
                        end else begin
                            store_byte(b);
                        end
                    end
                    PH_ESC: begin
                        store_byte(b);
                        phase = PH_FRAME;
                    end
                    default: begin
                        if (b == SYM_START) begin
                            phase    = PH_FRAME;
                            sum8     = '0;
                            end_run  = '0;
                            pos      = '0;
                            len_byte = '0;
                            volt_f   = '0;
                            curr_f   = '0;
                            cons_f   = '0;
                            pwr_f    = '0;
                            sum_ok   = 1'b0;
                        end
                    end
                endcase
            end else begin
                ticks = ticks + 32'd1;
                if (ticks >= interval_ms) begin
                    ticks = '0;
                    if (n_samples != 0) begin
                        r.report   = 1'b1;
                        r.avg_volt = rounded_mean(volt_total, n_samples);
                        r.avg_curr = rounded_mean(curr_total, n_samples);
                        r.avg_pwr  = rounded_mean(pwr_total, n_samples);
                        r.energy   = last_cons;
                    end
                    volt_total = '0;
                    curr_total = '0;
                    pwr_total  = '0;
                    n_samples  = '0;
                    last_cons  = '0;
                end
            end
            r.bad_frames = bad_frames;
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [79:0] got, logic [79:0] want);
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
            fail_count++;
        endtask

        task check_result(logic report, logic [79:0] data);
            t_meter_result want;
            logic [79:0]   want_data;
            string         names [5];
            names = '{"avg_voltage", "avg_current", "avg_power",
                      "energy_reading", "checksum_errors"};
            if (pending.size() == 0) begin
                report_mismatch("result with no request pending", data, '0);
            end else begin
                want      = pending.pop_front();
                want_data = {want.bad_frames, want.energy, want.avg_pwr,
                             want.avg_curr, want.avg_volt};
                if (report !== want.report)
                    report_mismatch("report_valid", report, want.report);
                for (int k = 0; k < 5; k++) begin
                    if (data[16*k +: 16] !== want_data[16*k +: 16])
                        report_mismatch(names[k], data[16*k +: 16], want_data[16*k +: 16]);
                end
            end
        endtask
    endclass

    meter_scoreboard sb = new();

    bit          tx_gaps    = 1'b1;     // sender inserts random gaps
    bit          rx_stalls  = 1'b1;     // receiver stalls at random
    bit          mid_ticks  = 1'b0;     // ticks sprinkled into frames
    int unsigned rx_wait    = 0;
    int unsigned items_sent = 0;
    t_request    frame_q[$];

    // ------------------------------------------------------------------------
    // monitors: note every accepted request, check every accepted result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    // receiver: random stall after each taken result, while stalls are enabled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            m_axis_tready <= 1'b1;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_wait = rx_stalls ? $urandom_range(0, 6) : 0;
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one request, after a random gap; returns at the edge that takes it
    task automatic send_request(logic mode, logic [7:0] value);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // hold off until every result is back, so the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // writes all four registers on consecutive cycles
    task automatic program_registers(logic [31:0] volt, logic [31:0] curr,
                                     logic [31:0] pwr, logic [31:0] ivl);
        logic [31:0] vals [4];
        logic [1:0]  regs [4];
        vals = '{volt, curr, pwr, ivl};
        regs = '{REG_VOLT_LIMIT, REG_CURR_LIMIT, REG_PWR_LIMIT, REG_INTERVAL};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= regs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            sb.write_register(regs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic void push_byte(logic [7:0] b);
        if (mid_ticks && $urandom_range(0, 9) == 0)
            frame_q.push_back('{tick: MODE_TICK, value: 8'($urandom)});
        frame_q.push_back('{tick: MODE_BYTE, value: b});
    endfunction

    // escapes the escape and end symbols, and now and then any byte
    function automatic void push_data(logic [7:0] b);
        if (b == SYM_ESC || b == SYM_END || $urandom_range(0, 19) == 0) push_byte(SYM_ESC);
        push_byte(b);
    endfunction

    // random content with framing symbols more often than chance
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 11))
            0:       return SYM_START;
            1:       return SYM_ESC;
            2:       return SYM_END;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly inside the bound, some at its edges, some anywhere
    function automatic logic [15:0] field_value(logic [14:0] lim);
        int l;
        int pick;
        l    = int'(lim);
        pick = $urandom_range(0, 9);
        if (pick < 6 && l > 0) return 16'(int'($urandom_range(0, 2 * l - 2)) - (l - 1));
        if (pick < 8) begin
            case ($urandom_range(0, 3))
                0:       return 16'(l);
                1:       return 16'(-l);
                2:       return 16'(l - 1);
                default: return 16'(1 - l);
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_limit();
        logic [31:0] lim;
        case ($urandom_range(0, 15))
            0:       lim = 0;
            1:       lim = 1;
            2, 3, 4: lim = 32767;
            default: lim = $urandom_range(100, 32766);
        endcase
        // junk above the register width must be dropped
        if ($urandom_range(0, 7) == 0) lim = lim | ($urandom & 32'hFFFF_8000);
        return lim;
    endfunction

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return 0;
            1, 2, 3: return 1;
            default: return $urandom_range(2, 6);
        endcase
    endfunction

    // builds one frame of the given shape and sends it
    task automatic send_frame(t_frame_kind kind, logic [15:0] volt, logic [15:0] curr,
                              logic [15:0] pwr);
        logic [7:0] body [28];
        logic [7:0] csum;
        int         body_len;
        t_request   req;
        for (int k = 0; k < FRAME_LENGTH; k++) body[k] = rand_byte();
        body[POS_LEN] = 8'(FRAME_LENGTH);
        if (kind == FR_BAD_LEN) begin
            body[POS_LEN] = 8'($urandom);
            if (body[POS_LEN] == FRAME_LENGTH) body[POS_LEN] = ~body[POS_LEN];
        end
        body[POS_VOLT_LO] = volt[7:0];
        body[POS_VOLT_HI] = volt[15:8];
        body[POS_CURR_LO] = curr[7:0];
        body[POS_CURR_HI] = curr[15:8];
        body[POS_PWR_LO]  = pwr[7:0];
        body[POS_PWR_HI]  = pwr[15:8];
        csum = '0;
        for (int k = 0; k < FRAME_LENGTH; k++) csum = csum + body[k];
        if (kind == FR_BAD_SUM) csum = csum ^ 8'($urandom_range(1, 255));
        body_len = (kind == FR_EARLY_CLOSE) ? $urandom_range(0, FRAME_LENGTH - 1)
                                            : FRAME_LENGTH;

        push_byte(SYM_START);
        for (int k = 0; k < body_len; k++) begin
            // a lone end symbol followed by data must not close the frame
            if ($urandom_range(0, 39) == 0) push_byte(SYM_END);
            push_data(body[k]);
        end
        if (body_len == FRAME_LENGTH) begin
            push_data(csum);
            // one trailing plain byte is allowed, a second one aborts
            if (kind == FR_OVERRUN) begin
                repeat ($urandom_range(1, 2)) push_byte(8'($urandom) & 8'h7F);
            end
            // escaped tail runs the position up to saturation
            if (kind == FR_ESC_TAIL) begin
                repeat ($urandom_range(1, 40)) begin
                    push_byte(SYM_ESC);
                    push_byte(8'($urandom));
                end
            end
        end
        push_byte(SYM_END);
        push_byte(SYM_END);

        while (frame_q.size() != 0) begin
            req = frame_q.pop_front();
            send_request(req.tick, req.value);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_start;
        int unsigned pick;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, register defaults after reset
        // bytes outside a frame are ignored
        send_request(MODE_BYTE, 8'h00);
        send_request(MODE_BYTE, 8'hFF);
        send_request(MODE_BYTE, SYM_END);
        send_request(MODE_BYTE, SYM_ESC);
        // ticks well short of the default interval
        send_request(MODE_TICK, 8'hA5);
        send_request(MODE_TICK, 8'h5A);
        // declared length wrong, aborted without an error
        send_request(MODE_BYTE, SYM_START);
        send_request(MODE_BYTE, 8'h00);
        send_request(MODE_BYTE, 8'h05);
        send_request(MODE_BYTE, 8'h11);
        // close before the checksum byte counts as a checksum error
        send_request(MODE_BYTE, SYM_START);
        send_request(MODE_BYTE, SYM_END);
        send_request(MODE_BYTE, SYM_END);
        // just inside the default bounds, then exactly on one, then far outside
        send_frame(FR_GOOD, 16'd429, 16'(-1999), 16'd8599);
        send_frame(FR_GOOD, 16'(-430), 16'd0, 16'd0);
        send_frame(FR_GOOD, 16'h8000, 16'd0, 16'd0);
        drain();
        program_registers(RST_VOLT_LIMIT, RST_CURR_LIMIT, RST_PWR_LIMIT, 32'd1);
        send_request(MODE_TICK, 8'h00);
        // interval that ends with no samples gives no report
        send_request(MODE_TICK, 8'hFF);
        // halves round away from zero
        send_frame(FR_GOOD, 16'd1, 16'(-1), 16'd3);
        send_frame(FR_GOOD, 16'd2, 16'(-2), 16'd0);
        send_request(MODE_TICK, 8'h3C);

        // random phases, each with its own register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            mid_ticks = $urandom_range(0, 1);
            if (ph == 0) begin
                program_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
            end else if (ph == 1) begin
                program_registers(pick_limit(), pick_limit(), pick_limit(), 32'd0);
            end else if (ph == RANDOM_PHASES - 1) begin
                program_registers(pick_limit(), pick_limit(), pick_limit(), 32'hFFFF_FFFF);
            end else begin
                program_registers(pick_limit(), pick_limit(), pick_limit(), pick_interval());
            end

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    case ($urandom_range(0, 15))
                        8, 9:    send_frame(FR_BAD_SUM, field_value(sb.volt_limit),
                                            field_value(sb.curr_limit),
                                            field_value(sb.pwr_limit));
                        10:      send_frame(FR_EARLY_CLOSE, field_value(sb.volt_limit),
                                            field_value(sb.curr_limit),
                                            field_value(sb.pwr_limit));
                        11:      send_frame(FR_BAD_LEN, field_value(sb.volt_limit),
                                            field_value(sb.curr_limit),
                                            field_value(sb.pwr_limit));
                        12:      send_frame(FR_OVERRUN, field_value(sb.volt_limit),
                                            field_value(sb.curr_limit),
                                            field_value(sb.pwr_limit));
                        13:      send_frame(FR_ESC_TAIL, field_value(sb.volt_limit),
                                            field_value(sb.curr_limit),
                                            field_value(sb.pwr_limit));
                        default: send_frame(FR_GOOD, field_value(sb.volt_limit),
                                            field_value(sb.curr_limit),
                                            field_value(sb.pwr_limit));
                    endcase
                end else if (pick < 18) begin
                    repeat ($urandom_range(1, 4)) send_request(MODE_TICK, 8'($urandom));
                end else if (pick == 18) begin
                    // line noise, never a start symbol
                    repeat ($urandom_range(1, 3)) send_request(MODE_BYTE, 8'($urandom) & 8'h7F);
                end else begin
                    // sender waits for every outstanding result
                    drain();
                end
            end
        end

        // wait for the last results, then a few quiet cycles
        drain();
        repeat (4) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/mfpa_pkg.sv
rtl/meter_frame_parse_average_top.sv
rtl/mfpa_chk.sv
tb/tb.sv
